>>> rtl/core/utf8_stream_decoder_top_defines.svh
// Assertion macros used by the decoder top.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned CONT_W  = 6;

  localparam logic [CP_W-1:0]   SUBST_CHAR = 21'h00003F;
  localparam logic [CP_W-1:0]   BMP_LIMIT  = 21'h010000;
  localparam logic [BYTE_W-1:0] NUL_MARK   = 8'h00;
  localparam logic [BYTE_W-1:0] NL_MARK    = 8'h01;

  // Lead byte patterns and their payload masks.
  localparam logic [BYTE_W-1:0] MASK_FOUR  = 8'b1111_1000;
  localparam logic [BYTE_W-1:0] PAT_FOUR   = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] MASK_THREE = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] PAT_THREE  = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] MASK_TWO   = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] PAT_TWO    = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] MASK_ONE   = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] PAY_TWO    = 8'b0001_1111;
  localparam logic [BYTE_W-1:0] PAY_THREE  = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] PAY_FOUR   = 8'b0000_0111;

  typedef enum logic [2:0] {
    LEAD_END,
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // Classifies a byte seen at a character boundary.
  function automatic lead_class_t classify_lead(input logic [BYTE_W-1:0] b);
    lead_class_t cls;
    if (b == NUL_MARK || b == NL_MARK) begin
      cls = LEAD_END;
    end else if ((b & MASK_FOUR) == PAT_FOUR) begin
      cls = LEAD_FOUR;
    end else if ((b & MASK_THREE) == PAT_THREE) begin
      cls = LEAD_THREE;
    end else if ((b & MASK_TWO) == PAT_TWO) begin
      cls = LEAD_TWO;
    end else if ((b & MASK_ONE) == '0) begin
      cls = LEAD_ASCII;
    end else begin
      cls = LEAD_BAD;
    end
    return cls;
  endfunction

endpackage

>>> rtl/core/utf8_stream_decoder_top.sv
// A byte that ends a character passes from the input register through the decode
// stage into the result register, which it enters once the result register is free.
// Throughput: one byte per cycle, set by the single decode stage between the input
// register and the result register; a stalled result holds both stages.
// Reset: synchronous, active low; clears the stage valids and the decoder state,
// leaving the decoder at a character boundary.
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top
  import u8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic [LEN_W-1:0]  out_seq_bytes,
  output logic              out_bad_lead,
  output logic              out_beyond_bmp,
  output logic              out_end_of_text
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_adv;

  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [CP_W-1:0]   partial_r, partial_nxt;
  logic [LEN_W-1:0]  seq_len_r, seq_len_nxt;

  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_bad;
  logic              emit_eot;
  lead_class_t       lead_cls;

  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   out_cp_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_bad_r;
  logic              out_bmp_r;
  logic              out_eot_r;

  // Pipeline control: the decode stage moves when the result register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  // Decode of the registered byte against the current sequence state.
  always_comb begin
    lead_cls    = classify_lead(s1_byte_r);
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    seq_len_nxt = seq_len_r;
    emit        = 1'b0;
    emit_cp     = partial_r;
    emit_len    = seq_len_r;
    emit_bad    = 1'b0;
    emit_eot    = 1'b0;
    if (pending_r != '0) begin
      // Continuation: shift in six payload bits without checking the form.
      partial_nxt = {partial_r[CP_W-CONT_W-1:0], s1_byte_r[CONT_W-1:0]};
      pending_nxt = pending_r - 1'b1;
      emit        = (pending_r == PEND_W'(1));
      emit_cp     = partial_nxt;
    end else begin
      unique case (lead_cls)
        LEAD_END: begin
          emit     = 1'b1;
          emit_cp  = '0;
          emit_len = LEN_W'(1);
          emit_eot = 1'b1;
        end
        LEAD_ASCII: begin
          emit     = 1'b1;
          emit_cp  = CP_W'(s1_byte_r);
          emit_len = LEN_W'(1);
        end
        LEAD_TWO: begin
          partial_nxt = CP_W'(s1_byte_r & PAY_TWO);
          pending_nxt = PEND_W'(1);
          seq_len_nxt = LEN_W'(2);
        end
        LEAD_THREE: begin
          partial_nxt = CP_W'(s1_byte_r & PAY_THREE);
          pending_nxt = PEND_W'(2);
          seq_len_nxt = LEN_W'(3);
        end
        LEAD_FOUR: begin
          partial_nxt = CP_W'(s1_byte_r & PAY_FOUR);
          pending_nxt = PEND_W'(3);
          seq_len_nxt = LEN_W'(4);
        end
        default: begin
          emit     = 1'b1;
          emit_cp  = SUBST_CHAR;
          emit_len = LEN_W'(1);
          emit_bad = 1'b1;
        end
      endcase
    end
  end

  // Sequence state advances once per byte leaving the decode stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      partial_r <= '0;
      seq_len_r <= '0;
    end else if (s1_adv) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      seq_len_r <= seq_len_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = s1_adv ? emit : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_adv && emit) begin
      out_cp_r  <= emit_cp;
      out_len_r <= emit_len;
      out_bad_r <= emit_bad;
      out_bmp_r <= (emit_cp >= BMP_LIMIT);
      out_eot_r <= emit_eot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = out_cp_r;
  assign out_seq_bytes   = out_len_r;
  assign out_bad_lead    = out_bad_r;
  assign out_beyond_bmp  = out_bmp_r;
  assign out_end_of_text = out_eot_r;

  // Checks on the decoder's own bookkeeping.
  `U8SD_ASSERT_NOW(a_len_tracks_pending, pending_r != '0,
    seq_len_r > LEN_W'(pending_r) && seq_len_r <= LEN_W'(4), "sequence length out of step with pending count")
  `U8SD_ASSERT_NOW(a_bad_is_single, out_valid_r && out_bad_r,
    out_len_r == LEN_W'(1) && out_cp_r == SUBST_CHAR && !out_eot_r, "bad lead result malformed")
  `U8SD_ASSERT_NEXT(a_emit_lands, s1_adv && emit,
    out_valid_r, "emitted result did not reach the result register")
  `U8SD_ASSERT_NOW(a_eot_is_zero, out_valid_r && out_eot_r,
    out_cp_r == '0 && !out_bmp_r && out_len_r == LEN_W'(1), "end of text result malformed")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import u8sd_pkg::*;

  // One decoded character as the decoder should report it.
  typedef struct {
    bit                hit;
    logic [CP_W-1:0]   cp;
    logic [LEN_W-1:0]  len;
    logic              bad;
    logic              beyond;
    logic              eot;
  } char_t;

  // One byte waiting to be sent; hold makes the sender wait for all results first.
  typedef struct {
    logic [BYTE_W-1:0] value;
    bit                hold;
  } text_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_RANDOM,
    RX_BLOCKED
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   out_code_point;
  logic [LEN_W-1:0]  out_seq_bytes;
  logic              out_bad_lead;
  logic              out_beyond_bmp;
  logic              out_end_of_text;

  text_byte_t text_bytes[$];
  char_t      expected_chars[$];
  int         fail_count = 0;

  // Decoder state as the predictor sees it.
  logic [PEND_W-1:0] cont_left = '0;
  logic [CP_W-1:0]   cp_acc = '0;
  logic [LEN_W-1:0]  char_len = '0;

  // Sender burst and gap counters.
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;
  int       rx_tick = 0;

  utf8_stream_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_seq_bytes   (out_seq_bytes),
    .out_bad_lead    (out_bad_lead),
    .out_beyond_bmp  (out_beyond_bmp),
    .out_end_of_text (out_end_of_text)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic char_t make_char(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                                      input logic bad, input logic eot);
    char_t c;
    c.hit    = 1'b1;
    c.cp     = cp;
    c.len    = len;
    c.bad    = bad;
    c.eot    = eot;
    c.beyond = (cp >= BMP_LIMIT);
    return c;
  endfunction

  // Advances the predicted decoder by one byte and returns the character it completes, if any.
  function automatic char_t decode_byte(input logic [BYTE_W-1:0] b);
    char_t       c;
    lead_class_t cls;
    c = '{hit: 1'b0, cp: '0, len: '0, bad: 1'b0, beyond: 1'b0, eot: 1'b0};
    if (cont_left != 0) begin
      // Inside a sequence every byte is taken as a continuation, unchecked.
      cp_acc = {cp_acc[CP_W-7:0], b[CONT_W-1:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) begin
        c = make_char(cp_acc, char_len, 1'b0, 1'b0);
      end
    end else begin
      if (b == NUL_MARK || b == NL_MARK) begin
        cls = LEAD_END;
      end else if (b[7:3] == 5'b11110) begin
        cls = LEAD_FOUR;
      end else if (b[7:4] == 4'b1110) begin
        cls = LEAD_THREE;
      end else if (b[7:5] == 3'b110) begin
        cls = LEAD_TWO;
      end else if (b[7] == 1'b0) begin
        cls = LEAD_ASCII;
      end else begin
        cls = LEAD_BAD;
      end
      case (cls)
        LEAD_END: begin
          c = make_char('0, 3'd1, 1'b0, 1'b1);
        end
        LEAD_FOUR: begin
          cp_acc = CP_W'(b[2:0]);
          cont_left = 2'd3;
          char_len = 3'd4;
        end
        LEAD_THREE: begin
          cp_acc = CP_W'(b[3:0]);
          cont_left = 2'd2;
          char_len = 3'd3;
        end
        LEAD_TWO: begin
          cp_acc = CP_W'(b[4:0]);
          cont_left = 2'd1;
          char_len = 3'd2;
        end
        LEAD_ASCII: begin
          c = make_char(CP_W'(b), 3'd1, 1'b0, 1'b0);
        end
        default: begin
          c = make_char(SUBST_CHAR, 3'd1, 1'b1, 1'b0);
        end
      endcase
    end
    return c;
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] value, input bit hold = 1'b0);
    text_byte_t t;
    t.value = value;
    t.hold  = hold;
    text_bytes.push_back(t);
  endtask

  // Queues one complete character sequence of random length and content.
  task automatic add_random_char();
    int n;
    n = $urandom_range(1, 4);
    case (n)
      1: add_byte(BYTE_W'($urandom_range(2, 127)));
      2: add_byte(8'hC0 | BYTE_W'($urandom_range(0, 31)));
      3: add_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
      default: add_byte(8'hF0 | BYTE_W'($urandom_range(0, 7)));
    endcase
    for (int i = 1; i < n; i++) begin
      add_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
    end
  endtask

  task automatic check_field(input string name, input logic [CP_W-1:0] exp_v,
                             input logic [CP_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Sender: presents queued bytes in bursts and predicts each transfer.
  always @(posedge clk) begin
    char_t c;
    bit    take;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        c = decode_byte(in_byte);
        if (c.hit) begin
          expected_chars.push_back(c);
        end
      end
      if (!(in_valid && !in_ready)) begin
        take = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (text_bytes.size() != 0 &&
                     !(text_bytes[0].hold && expected_chars.size() != 0)) begin
          take = 1'b1;
        end
        if (take) begin
          in_valid <= 1'b1;
          in_byte  <= text_bytes[0].value;
          void'(text_bytes.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls on its own pattern.
  always @(posedge clk) begin
    char_t c;
    logic  rdy;
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: code_point 0x%0h", out_code_point);
          fail_count++;
        end else begin
          c = expected_chars.pop_front();
          check_field("code_point", c.cp, out_code_point);
          check_field("seq_bytes", CP_W'(c.len), CP_W'(out_seq_bytes));
          check_field("bad_lead", CP_W'(c.bad), CP_W'(out_bad_lead));
          check_field("beyond_bmp", CP_W'(c.beyond), CP_W'(out_beyond_bmp));
          check_field("end_of_text", CP_W'(c.eot), CP_W'(out_end_of_text));
        end
      end
      if (rx_phase_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(5, 60);
      end else begin
        rx_phase_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:    rdy = 1'b1;
        RX_SPARSE:  rdy = (rx_tick % 3 == 0);
        RX_RANDOM:  rdy = 1'($urandom_range(0, 1));
        default:    rdy = (rx_phase_left < 2);
      endcase
      out_ready <= rdy;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed: end markers, ASCII limit, bad leads, each sequence length.
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'h7F);
    add_byte(8'h80);
    add_byte(8'hF8);
    add_byte(8'hFF);
    // Two-byte character whose continuation looks like a lead byte.
    add_byte(8'hC2);
    add_byte(8'hFF);
    add_byte(8'hE2);
    add_byte(8'h82);
    add_byte(8'hAC);
    // Largest value a four-byte sequence can carry.
    add_byte(8'hF7);
    add_byte(8'hBF);
    add_byte(8'hBF);
    add_byte(8'hBF);
    // Overlong form passes through as assembled.
    add_byte(8'hC0);
    add_byte(8'h80);
    // End markers inside a sequence are plain continuations.
    add_byte(8'hE0);
    add_byte(8'h00);
    add_byte(8'h01);
    // First value beyond the basic plane.
    add_byte(8'hF0);
    add_byte(8'h90);
    add_byte(8'h80);
    add_byte(8'h80);

    // Random part: mostly well-formed text, with noise and truncated sequences.
    add_byte(8'h41, 1'b1);
    while (text_bytes.size() < 1920) begin
      case ($urandom_range(0, 19))
        0, 1: add_byte(BYTE_W'($urandom_range(0, 255)));
        2: add_byte(BYTE_W'($urandom_range(0, 1)));
        3: begin
          // Lead byte whose sequence is cut short by another lead.
          add_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
          add_random_char();
        end
        default: add_random_char();
      endcase
      if (text_bytes.size() > 900 && text_bytes.size() < 905) begin
        text_bytes[text_bytes.size()-1].hold = 1'b1;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (text_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
